[rtl/core/assert_macros.svh]
// assertion macros used by the cache top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define LKV_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("lru cache check failed");
`define LKV_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("lru cache sequence check failed");
`else
`define LKV_ASSERT(lbl, cond)
`define LKV_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

[rtl/core/lkv_pkg.sv]
// shared types and constants of the lru key/value cache
package lkv_pkg;

  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int CAP_W = 5;

  localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;
  localparam logic signed [VAL_W-1:0] MISS_VALUE = -32'sd1;

  typedef enum logic {
    FUNC_GET = 1'b0,
    FUNC_PUT = 1'b1
  } lkv_func_t;

  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_COMMIT = 1'b1
  } lkv_state_t;

  // control broadcast from the sequencer to every cell
  typedef struct packed {
    logic capture;
    logic commit;
    logic hit;
  } lkv_ctrl_t;

endpackage

[rtl/core/lkv_req_if.sv]
// request channel: get or put of one key
interface lkv_req_if;
  logic                                       valid;
  logic                                       ready;
  lkv_pkg::lkv_func_t                         func;
  logic signed [lkv_pkg::KEY_W-1:0]           key;
  logic signed [lkv_pkg::VAL_W-1:0]           value;

  modport source (output valid, output func, output key, output value, input ready);
  modport sink (input valid, input func, input key, input value, output ready);
endinterface

[rtl/core/lkv_rsp_if.sv]
// result channel: hit flag, read data and eviction flag
interface lkv_rsp_if;
  logic                                       valid;
  logic                                       ready;
  logic                                       hit;
  logic signed [lkv_pkg::VAL_W-1:0]           read_value;
  logic                                       evicted;

  modport source (output valid, output hit, output read_value, output evicted, input ready);
  modport sink (input valid, input hit, input read_value, input evicted, output ready);
endinterface

[rtl/core/lkv_cfg_if.sv]
// configuration write channel for the capacity register
interface lkv_cfg_if;
  logic                                       valid;
  logic                                       ready;
  logic [lkv_pkg::CAP_W-1:0]                  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/core/lru_key_value_cache_unit.sv]
// top level of the lru key/value cache: sequencer, capacity register and cell row
//
// Fully associative key/value cache with least-recently-used replacement, held as
// a row of MAX_ENTRIES cells in recency order (head = most recent). A request is
// taken in the idle state, where every live cell compares its key; in the commit
// state, once the output register is free, the matched or inserted entry moves
// to the head (a get that misses moves nothing) while the cells in front of it
// hand their contents one place down, and the result is loaded into the output
// register. A waiting result does not block the next request; only the commit
// state waits for the output register to drain. The capacity register resets
// to 16 and its effective value is clamped to 1..MAX_ENTRIES; writes are taken
// at any time but are meant for an idle block.
`include "assert_macros.svh"

module lru_key_value_cache_unit #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  lkv_req_if.sink    in_ch,
  lkv_rsp_if.source  out_ch,
  lkv_cfg_if.sink    cfg_ch
);

  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int EW = (CW > lkv_pkg::CAP_W) ? CW : lkv_pkg::CAP_W;
  localparam logic [EW-1:0] MAX_EXT = EW'(MAX_ENTRIES);
  localparam logic [EW-1:0] ONE_EXT = EW'(1);

  lkv_pkg::lkv_state_t state_r, state_nxt;

  logic [lkv_pkg::CAP_W-1:0]        capacity_r;
  logic [CW-1:0]                    count_r, count_nxt;
  lkv_pkg::lkv_func_t               func_r;
  logic signed [lkv_pkg::KEY_W-1:0] key_r;
  logic signed [lkv_pkg::VAL_W-1:0] value_r;

  logic                             out_valid_r;
  logic                             out_hit_r;
  logic signed [lkv_pkg::VAL_W-1:0] out_value_r;
  logic                             out_evicted_r;

  logic                             in_ready;
  logic                             out_free;
  logic                             commit_fire;
  logic                             accept;
  logic                             hit;
  logic                             full;
  logic                             put_miss;
  logic [EW-1:0]                    cap_ext, cap_eff, cnt_ext, ins_ext;
  logic [CW-1:0]                    ins_pos;
  logic signed [lkv_pkg::VAL_W-1:0] hit_val;
  logic signed [lkv_pkg::VAL_W-1:0] head_val;
  lkv_pkg::lkv_ctrl_t               ctrl;

  logic signed [lkv_pkg::KEY_W-1:0] cell_key  [MAX_ENTRIES];
  logic signed [lkv_pkg::VAL_W-1:0] cell_val  [MAX_ENTRIES];
  logic signed [lkv_pkg::VAL_W-1:0] cell_mval [MAX_ENTRIES];
  logic [MAX_ENTRIES:0]             sel_w;
  logic [MAX_ENTRIES-1:0]           match_vec;

  // sequencer
  assign out_free = ~out_valid_r | out_ch.ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lkv_pkg::ST_IDLE: begin
        if (in_ch.valid) state_nxt = lkv_pkg::ST_COMMIT;
      end
      lkv_pkg::ST_COMMIT: begin
        if (out_free) state_nxt = lkv_pkg::ST_IDLE;
      end
      default: state_nxt = lkv_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    commit_fire = 1'b0;
    unique case (state_r)
      lkv_pkg::ST_IDLE: in_ready = rst_n;
      lkv_pkg::ST_COMMIT: commit_fire = out_free;
      default: in_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lkv_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ch.ready = in_ready;
  assign accept = in_ch.valid & in_ready;

  // capacity register
  assign cfg_ch.ready = rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= lkv_pkg::CAPACITY_RESET;
    end else if (cfg_ch.valid) begin
      capacity_r <= cfg_ch.data;
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      func_r  <= in_ch.func;
      key_r   <= in_ch.key;
      value_r <= in_ch.value;
    end
  end

  // insertion position: clamp the entry count to capacity-1 when full
  assign cap_ext = EW'(capacity_r);
  assign cap_eff = (cap_ext == '0) ? ONE_EXT : ((cap_ext > MAX_EXT) ? MAX_EXT : cap_ext);
  assign cnt_ext = EW'(count_r);
  assign full    = (cnt_ext >= cap_eff);
  assign ins_ext = full ? (cap_eff - ONE_EXT) : cnt_ext;
  assign ins_pos = ins_ext[CW-1:0];

  assign hit      = sel_w[0];
  assign put_miss = (func_r == lkv_pkg::FUNC_PUT) & ~hit;

  always_comb begin
    hit_val = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      hit_val = hit_val | cell_mval[i];
    end
  end

  assign head_val = (func_r == lkv_pkg::FUNC_GET) ? hit_val : value_r;

  assign ctrl.capture = accept;
  // a get that misses leaves the row untouched
  assign ctrl.commit  = commit_fire & ((func_r == lkv_pkg::FUNC_PUT) | hit);
  assign ctrl.hit     = hit;

  always_comb begin
    count_nxt = count_r;
    if (commit_fire && put_miss) begin
      count_nxt = CW'(ins_ext + ONE_EXT);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // cell row, head at index 0
  assign sel_w[MAX_ENTRIES] = 1'b0;

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    logic signed [lkv_pkg::KEY_W-1:0] prev_key;
    logic signed [lkv_pkg::VAL_W-1:0] prev_val;

    if (i == 0) begin : g_head
      assign prev_key = key_r;
      assign prev_val = head_val;
    end else begin : g_body
      assign prev_key = cell_key[i-1];
      assign prev_val = cell_val[i-1];
    end

    lkv_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .search_key (in_ch.key),
      .count      (count_r),
      .ins_pos    (ins_pos),
      .prev_key   (prev_key),
      .prev_val   (prev_val),
      .sel_in     (sel_w[i+1]),
      .key_q      (cell_key[i]),
      .val_q      (cell_val[i]),
      .sel_out    (sel_w[i]),
      .match_val  (cell_mval[i]),
      .match      (match_vec[i])
    );
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit_fire) begin
      out_hit_r     <= hit;
      out_evicted_r <= put_miss & full;
      if (func_r == lkv_pkg::FUNC_PUT) begin
        out_value_r <= '0;
      end else begin
        out_value_r <= hit ? hit_val : lkv_pkg::MISS_VALUE;
      end
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.hit        = out_hit_r;
  assign out_ch.read_value = out_value_r;
  assign out_ch.evicted    = out_evicted_r;

  // checks
  `LKV_ASSERT(a_count_bound, count_r <= CW'(MAX_ENTRIES))
  `LKV_ASSERT(a_keys_unique, (state_r != lkv_pkg::ST_COMMIT) || $onehot0(match_vec))
  `LKV_ASSERT_NEXT(a_insert_grows, commit_fire && put_miss, count_r != '0)
  `LKV_ASSERT(a_evict_on_miss, !(out_valid_r && out_evicted_r) || !out_hit_r)

endmodule

[rtl/core/lkv_cell.sv]
// one recency position of the cache: key, value and match flag
module lkv_cell #(
  parameter int IDX = 0,
  parameter int CW  = 5
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  lkv_pkg::lkv_ctrl_t                 ctrl,
  input  logic signed [lkv_pkg::KEY_W-1:0]   search_key,
  input  logic [CW-1:0]                      count,
  input  logic [CW-1:0]                      ins_pos,
  input  logic signed [lkv_pkg::KEY_W-1:0]   prev_key,
  input  logic signed [lkv_pkg::VAL_W-1:0]   prev_val,
  input  logic                               sel_in,
  output logic signed [lkv_pkg::KEY_W-1:0]   key_q,
  output logic signed [lkv_pkg::VAL_W-1:0]   val_q,
  output logic                               sel_out,
  output logic signed [lkv_pkg::VAL_W-1:0]   match_val,
  output logic                               match
);

  localparam logic [CW-1:0] CIDX = CW'(IDX);

  logic signed [lkv_pkg::KEY_W-1:0] key_r;
  logic signed [lkv_pkg::VAL_W-1:0] val_r;
  logic                             match_r;
  logic                             live;
  logic                             shift;

  assign live = (CIDX < count);
  // sel_out is set here and in every position nearer the head than the match
  assign sel_out = sel_in | match_r;
  assign shift = ctrl.commit & (ctrl.hit ? sel_out : (CIDX <= ins_pos));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
    end else if (ctrl.capture) begin
      match_r <= live & (key_r == search_key);
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      key_r <= prev_key;
      val_r <= prev_val;
    end
  end

  assign key_q = key_r;
  assign val_q = val_r;
  assign match_val = match_r ? val_r : '0;
  assign match = match_r;

endmodule
